// File: rtl/b64d_pkg.sv
package b64d_pkg;

  localparam int QueueDepthDefault = 4;

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       end_of_text;
  } char_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_of_text;
  } byte_item_t;

  // one group of decoded bytes, most significant byte first
  // nbytes of zero stands for an empty end marker
  typedef struct packed {
    logic [23:0] bytes;
    logic [1:0]  nbytes;
    logic        last;
  } group_t;

  typedef struct packed {
    logic   empty;
    logic   full;
    group_t head;
  } queue_status_t;

endpackage

// File: rtl/base64_stream_decoder.sv
// channel   direction  payload       handshake
// char      in         char_item_t   char_valid / char_stall
// byte      out        byte_item_t   byte_valid / byte_stall
//
// one character is taken per cycle while the group queue has room
// each result leaves the output register one per cycle while byte_stall is low,
// so a full group holds the queue head until its bytes leave: 3 bytes per 4 chars
// reset clears decode state, the queue pointers and the output valid
// char_stall rises only when the group queue is full
module base64_stream_decoder #(
  parameter int QueueDepth = b64d_pkg::QueueDepthDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  output logic                  char_stall,
  input  b64d_pkg::char_item_t  char_data,
  output logic                  byte_valid,
  input  logic                  byte_stall,
  output b64d_pkg::byte_item_t  byte_data
);
  import b64d_pkg::*;

  logic          push;
  logic          pop;
  group_t        push_group;
  queue_status_t status;

  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data),
    .queue_full (status.full),
    .push       (push),
    .push_group (push_group)
  );

  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .pop        (pop),
    .status     (status)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .status     (status),
    .pop        (pop),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data)
  );

endmodule

// File: rtl/b64d_front.sv
module b64d_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  output logic                  char_stall,
  input  b64d_pkg::char_item_t  char_data,
  input  logic                  queue_full,
  output logic                  push,
  output b64d_pkg::group_t      push_group
);
  import b64d_pkg::*;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } sextet_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    s.ok    = 1'b1;
    s.value = 6'd0;
    if (c >= "A" && c <= "Z") begin
      s.value = 6'(c - 8'd65);
    end else if (c >= "a" && c <= "z") begin
      s.value = 6'(c - 8'd71);
    end else if (c >= "0" && c <= "9") begin
      s.value = 6'(c + 8'd4);
    end else if (c == "+") begin
      s.value = 6'd62;
    end else if (c == "/") begin
      s.value = 6'd63;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

  logic [1:0]  sextet_count, sextet_count_next;
  logic [17:0] held_sextets, held_sextets_next;
  logic        halted, halted_next;

  sextet_t     sx;
  logic        accept;
  logic        take;
  logic        complete;
  logic [1:0]  count_after;
  logic [17:0] held_after;

  assign char_stall = queue_full;
  assign accept     = char_valid && !char_stall;

  always_comb begin
    sx       = sextet_of(char_data.char_code);
    take     = char_data.has_char && !halted && sx.ok;
    complete = take && (sextet_count == 2'd3);

    halted_next = halted;
    if (char_data.has_char && !halted && !sx.ok) begin
      halted_next = 1'b1;
    end

    count_after = sextet_count;
    held_after  = held_sextets;
    if (complete) begin
      count_after = 2'd0;
      held_after  = 18'd0;
    end else if (take) begin
      count_after = sextet_count + 2'd1;
      held_after  = {held_sextets[11:0], sx.value};
    end

    push_group.bytes  = {held_sextets, sx.value};
    push_group.nbytes = 2'd3;
    push_group.last   = char_data.end_of_text;
    if (!complete) begin
      push_group.last = 1'b1;
      case (count_after)
        2'd2: begin
          push_group.bytes  = {held_after[11:0], 12'd0};
          push_group.nbytes = 2'd1;
        end
        2'd3: begin
          push_group.bytes  = {held_after, 6'd0};
          push_group.nbytes = 2'd2;
        end
        default: begin
          push_group.bytes  = 24'd0;
          push_group.nbytes = 2'd0;
        end
      endcase
    end

    push = accept && (complete || char_data.end_of_text);

    sextet_count_next = count_after;
    held_sextets_next = held_after;
    if (char_data.end_of_text) begin
      sextet_count_next = 2'd0;
      held_sextets_next = 18'd0;
      halted_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_count <= 2'd0;
      held_sextets <= 18'd0;
      halted       <= 1'b0;
    end else if (accept) begin
      sextet_count <= sextet_count_next;
      held_sextets <= held_sextets_next;
      halted       <= halted_next;
    end
  end

endmodule

// File: rtl/b64d_queue.sv
module b64d_queue #(
  parameter int Depth = b64d_pkg::QueueDepthDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  b64d_pkg::group_t        push_group,
  input  logic                    pop,
  output b64d_pkg::queue_status_t status
);
  import b64d_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  group_t          mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  always_comb begin
    status.empty = (count == '0);
    status.full  = (count == CntW'(Depth));
    status.head  = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/b64d_back.sv
module b64d_back (
  input  logic                    clk,
  input  logic                    rst,
  input  b64d_pkg::queue_status_t status,
  output logic                    pop,
  output logic                    byte_valid,
  input  logic                    byte_stall,
  output b64d_pkg::byte_item_t    byte_data
);
  import b64d_pkg::*;

  logic [1:0] idx;
  logic       advance;
  logic       final_one;
  logic [7:0] sel_byte;

  always_comb begin
    advance   = !status.empty && (!byte_valid || !byte_stall);
    final_one = (status.head.nbytes == 2'd0) || (idx == status.head.nbytes - 2'd1);
    pop       = advance && final_one;
    case (idx)
      2'd0:    sel_byte = status.head.bytes[23:16];
      2'd1:    sel_byte = status.head.bytes[15:8];
      2'd2:    sel_byte = status.head.bytes[7:0];
      default: sel_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      idx        <= 2'd0;
    end else begin
      if (advance) begin
        byte_valid <= 1'b1;
        idx        <= final_one ? 2'd0 : idx + 2'd1;
      end else if (!byte_stall) begin
        byte_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_data.data_byte    <= (status.head.nbytes == 2'd0) ? 8'd0 : sel_byte;
      byte_data.byte_present <= (status.head.nbytes != 2'd0);
      byte_data.last_of_text <= status.head.last && final_one;
    end
  end

endmodule
